>>> sv/isa_pkg.sv
// Shared types, constants and codes for the indexed shift array.
`timescale 1ns / 1ps

package isa_pkg;

	// Capacity of the list and the derived widths.
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = 8;
	localparam int MAG_W = IDX_W - 1;
	localparam int POS_W = (CNT_W > MAG_W) ? CNT_W : MAG_W;
	localparam int DATA_W = 32;
	localparam int ENTRY_W = 2 * DATA_W;
	localparam int COUNT_OUT_W = 7;
	localparam int ACT_W = 2;
	localparam int STAT_W = 2;

	// Read results are gathered in registered groups of this many cells.
	localparam int GRP = 8;
	localparam int GROUPS = (DEPTH + GRP - 1) / GRP;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ   = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_REMOVE = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored entry: value in the upper half, priority in the lower half.
	typedef logic [ENTRY_W-1:0] entry_t;

	// Controls broadcast to every cell of the row.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             rd;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

>>> sv/isa_cell.sv
// One cell of the row: holds one entry and shifts it to or from its neighbours.
`timescale 1ns / 1ps

module isa_cell (
	input  logic                      clk,
	input  logic [isa_pkg::POS_W-1:0] my_pos,
	input  isa_pkg::cell_ctrl_t       ctrl,
	input  isa_pkg::entry_t           new_entry,
	input  isa_pkg::entry_t           lower_entry,
	input  isa_pkg::entry_t           upper_entry,
	output isa_pkg::entry_t           entry,
	output isa_pkg::entry_t           rd_entry
);

	isa_pkg::entry_t entry_q;

	// An insert moves cells above the position up and writes the new entry at it;
	// a remove pulls every cell from the position upwards down by one place.
	always_ff @(posedge clk) begin
		if (ctrl.ins && (my_pos > ctrl.pos)) begin
			entry_q <= lower_entry;
		end else if (ctrl.ins && (my_pos == ctrl.pos)) begin
			entry_q <= new_entry;
		end else if (ctrl.rem && (my_pos >= ctrl.pos)) begin
			entry_q <= upper_entry;
		end
	end

	assign entry = entry_q;

	// Only the addressed cell drives the read bus; the others give zero.
	assign rd_entry = (ctrl.rd && (my_pos == ctrl.pos)) ? entry_q : '0;

endmodule

>>> sv/indexed_shift_array.sv
// Top level of the indexed shift array: control, the row of cells and the result pipeline.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  item in  | start, busy        | action, index, entry_value, entry_priority
//  result   | done (one cycle)   | read_value, read_priority, count_now, is_empty,
//           |                    | status
//
// An item is taken in every cycle; busy stays low. The row of cells shifts in the
// cycle of acceptance, so the next item already sees the updated list.
// Each result passes the s1 and s2 pipeline registers: the read is gathered through a
// registered two-level OR tree over the cells.
// Reset clears the count and the pipeline valid bits; cell contents are not reset.
// The receiver cannot stall, so nothing ever waits inside the block.
`timescale 1ns / 1ps

module indexed_shift_array (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [isa_pkg::ACT_W-1:0]            action,
	input  logic signed [isa_pkg::IDX_W-1:0]     index,
	input  logic signed [isa_pkg::DATA_W-1:0]    entry_value,
	input  logic signed [isa_pkg::DATA_W-1:0]    entry_priority,
	output logic                                 done,
	output logic signed [isa_pkg::DATA_W-1:0]    read_value,
	output logic signed [isa_pkg::DATA_W-1:0]    read_priority,
	output logic [isa_pkg::COUNT_OUT_W-1:0]      count_now,
	output logic                                 is_empty,
	output logic [isa_pkg::STAT_W-1:0]           status
);

	logic [isa_pkg::CNT_W-1:0] count_q;
	logic [isa_pkg::CNT_W-1:0] count_nxt;
	logic [isa_pkg::POS_W-1:0] idx_u;
	logic                      idx_neg;
	logic                      in_range;
	logic                      full;
	isa_pkg::status_t          stat_d;
	isa_pkg::cell_ctrl_t       ctrl;
	isa_pkg::entry_t           new_entry;
	isa_pkg::entry_t           cell_q   [isa_pkg::DEPTH];
	isa_pkg::entry_t           rd_bus   [isa_pkg::DEPTH];
	isa_pkg::entry_t           grp_or   [isa_pkg::GROUPS];

	// Pipeline registers.
	logic                      valid_s1;
	isa_pkg::status_t          status_s1;
	logic [isa_pkg::CNT_W-1:0] count_s1;
	isa_pkg::entry_t           grp_s1   [isa_pkg::GROUPS];
	logic                      valid_s2;
	isa_pkg::status_t          status_s2;
	logic [isa_pkg::CNT_W-1:0] count_s2;
	isa_pkg::entry_t           rd_s2;
	isa_pkg::entry_t           rd_all;

	assign busy = 1'b0;

	// Index decoding and range checks against the current count.
	assign idx_neg   = index[isa_pkg::IDX_W-1];
	assign idx_u     = isa_pkg::POS_W'(index[isa_pkg::MAG_W-1:0]);
	assign in_range  = !idx_neg && (idx_u < isa_pkg::POS_W'(count_q));
	assign full      = (count_q == isa_pkg::CNT_W'(isa_pkg::DEPTH));
	assign new_entry = {entry_value, entry_priority};

	// Decode the action into cell controls, the status and the next count.
	always_comb begin
		ctrl      = '0;
		stat_d    = isa_pkg::ST_OK;
		count_nxt = count_q;
		unique case (isa_pkg::action_t'(action))
			isa_pkg::ACT_READ: begin
				if (!in_range) begin
					stat_d = isa_pkg::ST_RANGE;
				end else begin
					ctrl.rd  = start;
					ctrl.pos = idx_u;
				end
			end
			isa_pkg::ACT_APPEND: begin
				if (full) begin
					stat_d = isa_pkg::ST_FULL;
				end else begin
					ctrl.ins  = start;
					ctrl.pos  = isa_pkg::POS_W'(count_q);
					count_nxt = count_q + 1'b1;
				end
			end
			isa_pkg::ACT_INSERT: begin
				if (idx_neg) begin
					stat_d = isa_pkg::ST_RANGE;
				end else if (full) begin
					stat_d = isa_pkg::ST_FULL;
				end else begin
					ctrl.ins  = start;
					ctrl.pos  = in_range ? idx_u : isa_pkg::POS_W'(count_q);
					count_nxt = count_q + 1'b1;
				end
			end
			isa_pkg::ACT_REMOVE: begin
				if (!in_range) begin
					stat_d = isa_pkg::ST_RANGE;
				end else begin
					ctrl.rem  = start;
					ctrl.pos  = idx_u;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				stat_d = isa_pkg::ST_OK;
			end
		endcase
	end

	// The row of cells; the end cells take their own entry at the open side.
	for (genvar i = 0; i < isa_pkg::DEPTH; i++) begin : g_cell
		isa_pkg::entry_t lower_in;
		isa_pkg::entry_t upper_in;

		if (i == 0) begin : g_first
			assign lower_in = cell_q[i];
		end else begin : g_mid_lo
			assign lower_in = cell_q[i-1];
		end

		if (i == isa_pkg::DEPTH - 1) begin : g_last
			assign upper_in = cell_q[i];
		end else begin : g_mid_hi
			assign upper_in = cell_q[i+1];
		end

		isa_cell u_cell (
			.clk         (clk),
			.my_pos      (isa_pkg::POS_W'(i)),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.lower_entry (lower_in),
			.upper_entry (upper_in),
			.entry       (cell_q[i]),
			.rd_entry    (rd_bus[i])
		);
	end

	// First level of the read tree: OR of each group of cells.
	always_comb begin
		for (int g = 0; g < isa_pkg::GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < isa_pkg::GRP; k++) begin
				if (g * isa_pkg::GRP + k < isa_pkg::DEPTH) begin
					grp_or[g] = grp_or[g] | rd_bus[g * isa_pkg::GRP + k];
				end
			end
		end
	end

	// Second level of the read tree: OR over the registered groups.
	always_comb begin
		rd_all = '0;
		for (int g = 0; g < isa_pkg::GROUPS; g++) begin
			rd_all = rd_all | grp_s1[g];
		end
	end

	// Count register and the valid bits of the result pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (start) begin
				count_q <= count_nxt;
			end
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Result payload through the two pipeline stages.
	always_ff @(posedge clk) begin
		status_s1 <= stat_d;
		count_s1  <= count_nxt;
		for (int g = 0; g < isa_pkg::GROUPS; g++) begin
			grp_s1[g] <= grp_or[g];
		end
		status_s2 <= status_s1;
		count_s2  <= count_s1;
		rd_s2     <= rd_all;
	end

	assign done          = valid_s2;
	assign read_value    = rd_s2[isa_pkg::ENTRY_W-1:isa_pkg::DATA_W];
	assign read_priority = rd_s2[isa_pkg::DATA_W-1:0];
	assign count_now     = isa_pkg::COUNT_OUT_W'(count_s2);
	assign is_empty      = (count_s2 == '0);
	assign status        = status_s2;

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= isa_pkg::CNT_W'(isa_pkg::DEPTH))
		else $error("count above capacity");

	// The count moves by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 ((count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
		(count_q + 1'b1 == $past(count_q))))
		else $error("count jumped by more than one");

	// A full status is only reported with the list at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == isa_pkg::ST_FULL)) |->
		(count_s2 == isa_pkg::CNT_W'(isa_pkg::DEPTH)))
		else $error("full status below capacity");

	// A failed item never returns read data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != isa_pkg::ST_OK)) |-> ((read_value == '0) && (read_priority == '0)))
		else $error("read data on failed item");

endmodule

>>> dv/indexed_shift_array_tb.sv
// Self-checking testbench for the indexed shift array: directed table, then random phases.
`timescale 1ns / 1ps

module indexed_shift_array_tb;

	localparam int ITEMS_TOTAL = 650;
	localparam int DIR_ROWS = 22;

	// One result as the list should report it.
	typedef struct packed {
		logic [isa_pkg::DATA_W-1:0]      rv;
		logic [isa_pkg::DATA_W-1:0]      rp;
		logic [isa_pkg::COUNT_OUT_W-1:0] cnt;
		logic                            empty;
		isa_pkg::status_t                st;
	} list_result_t;

	// One row of the directed table; typed rows carry their own expected result.
	typedef struct packed {
		isa_pkg::action_t           act;
		logic [isa_pkg::IDX_W-1:0]  idx;
		logic [isa_pkg::DATA_W-1:0] val;
		logic [isa_pkg::DATA_W-1:0] pri;
		logic                       typed;
		list_result_t               want;
	} stim_row_t;

	localparam list_result_t NO_WANT = '{32'h0, 32'h0, 7'd0, 1'b0, isa_pkg::ST_OK};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [isa_pkg::ACT_W-1:0] action;
	logic signed [isa_pkg::IDX_W-1:0] index;
	logic signed [isa_pkg::DATA_W-1:0] entry_value;
	logic signed [isa_pkg::DATA_W-1:0] entry_priority;
	logic done;
	logic signed [isa_pkg::DATA_W-1:0] read_value;
	logic signed [isa_pkg::DATA_W-1:0] read_priority;
	logic [isa_pkg::COUNT_OUT_W-1:0] count_now;
	logic is_empty;
	logic [isa_pkg::STAT_W-1:0] status;

	// Shadow copy of the list kept by the predictor.
	logic [isa_pkg::DATA_W-1:0] shadow_val [isa_pkg::DEPTH];
	logic [isa_pkg::DATA_W-1:0] shadow_pri [isa_pkg::DEPTH];
	int shadow_len;

	list_result_t owed_results [$];
	list_result_t seen_want;
	stim_row_t dir_tab [DIR_ROWS];
	bit calm;
	int n_sent, n_checked, n_bad, n_ok, n_range, n_full, peak_len;

	indexed_shift_array dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.index          (index),
		.entry_value    (entry_value),
		.entry_priority (entry_priority),
		.done           (done),
		.read_value     (read_value),
		.read_priority  (read_priority),
		.count_now      (count_now),
		.is_empty       (is_empty),
		.status         (status)
	);

	always #5 clk = ~clk;

	// Apply one item to the shadow list and return the result it should give.
	function automatic list_result_t next_list_result(isa_pkg::action_t act,
			logic [isa_pkg::IDX_W-1:0] idx,
			logic [isa_pkg::DATA_W-1:0] v, logic [isa_pkg::DATA_W-1:0] p);
		list_result_t r;
		int pos;
		int at;
		r = NO_WANT;
		pos = int'($signed(idx));
		case (act)
			isa_pkg::ACT_READ: begin
				if (pos < 0 || pos >= shadow_len) begin
					r.st = isa_pkg::ST_RANGE;
				end else begin
					r.rv = shadow_val[pos];
					r.rp = shadow_pri[pos];
				end
			end
			isa_pkg::ACT_APPEND, isa_pkg::ACT_INSERT: begin
				// A negative insert index is rejected before the list is checked for room.
				if (act == isa_pkg::ACT_INSERT && pos < 0) begin
					r.st = isa_pkg::ST_RANGE;
				end else if (shadow_len >= isa_pkg::DEPTH) begin
					r.st = isa_pkg::ST_FULL;
				end else begin
					at = (act == isa_pkg::ACT_APPEND || pos > shadow_len) ? shadow_len : pos;
					for (int i = shadow_len; i > at; i--) begin
						shadow_val[i] = shadow_val[i-1];
						shadow_pri[i] = shadow_pri[i-1];
					end
					shadow_val[at] = v;
					shadow_pri[at] = p;
					shadow_len++;
				end
			end
			default: begin
				if (pos < 0 || pos >= shadow_len) begin
					r.st = isa_pkg::ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < shadow_len; i++) begin
						shadow_val[i] = shadow_val[i+1];
						shadow_pri[i] = shadow_pri[i+1];
					end
					shadow_len--;
				end
			end
		endcase
		r.cnt = isa_pkg::COUNT_OUT_W'(shadow_len);
		r.empty = (shadow_len == 0);
		return r;
	endfunction

	// Offer one item, wait for it to be taken and record what it should produce.
	task automatic send_item(input isa_pkg::action_t act,
			input logic [isa_pkg::IDX_W-1:0] idx,
			input logic [isa_pkg::DATA_W-1:0] v, input logic [isa_pkg::DATA_W-1:0] p,
			input logic typed, input list_result_t want);
		list_result_t got;
		while (!calm && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		index <= idx;
		entry_value <= v;
		entry_priority <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		got = next_list_result(act, idx, v, p);
		owed_results.push_back(typed ? want : got);
		n_sent++;
		case (got.st)
			isa_pkg::ST_OK: n_ok++;
			isa_pkg::ST_RANGE: n_range++;
			default: n_full++;
		endcase
		if (shadow_len > peak_len) peak_len = shadow_len;
	endtask

	// Compare every strobed result with the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: value %h priority %h count %0d %0b %0d",
						read_value, read_priority, count_now, is_empty, status);
			end else begin
				seen_want = owed_results.pop_front();
				n_checked++;
				if (read_value !== seen_want.rv || read_priority !== seen_want.rp ||
						count_now !== seen_want.cnt || is_empty !== seen_want.empty ||
						status !== seen_want.st) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("mismatch on result %0d: expected %h %h count %0d %0b %0d",
							n_checked, seen_want.rv, seen_want.rp, seen_want.cnt,
							seen_want.empty, seen_want.st);
						$display("    got %h %h count %0d %0b %0d",
							read_value, read_priority, count_now, is_empty, status);
					end
				end
			end
		end
	end

	// Main sequence: reset, the directed table, then random fill, drain and mixed phases.
	initial begin
		int phase;
		int mode;
		int phase_len;
		int roll;
		isa_pkg::action_t act;
		logic [isa_pkg::IDX_W-1:0] idx;
		start <= 1'b0;
		action <= isa_pkg::ACT_READ;
		index <= '0;
		entry_value <= '0;
		entry_priority <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		shadow_len = 0;
		for (int i = 0; i < isa_pkg::DEPTH; i++) begin
			shadow_val[i] = '0;
			shadow_pri[i] = '0;
		end

		dir_tab = '{
			// Empty list straight after reset: everything indexed is out of range.
			'{isa_pkg::ACT_READ, 8'h00, 32'h0, 32'h0, 1'b1,
				'{32'h0, 32'h0, 7'd0, 1'b1, isa_pkg::ST_RANGE}},
			'{isa_pkg::ACT_REMOVE, 8'h00, 32'h0, 32'h0, 1'b1,
				'{32'h0, 32'h0, 7'd0, 1'b1, isa_pkg::ST_RANGE}},
			'{isa_pkg::ACT_INSERT, 8'hFF, 32'h1, 32'h1, 1'b1,
				'{32'h0, 32'h0, 7'd0, 1'b1, isa_pkg::ST_RANGE}},
			'{isa_pkg::ACT_INSERT, 8'h80, 32'h1, 32'h1, 1'b1,
				'{32'h0, 32'h0, 7'd0, 1'b1, isa_pkg::ST_RANGE}},
			// Extremes of value and priority; append ignores its index.
			'{isa_pkg::ACT_APPEND, 8'h00, 32'h7FFFFFFF, 32'h80000000, 1'b0, NO_WANT},
			'{isa_pkg::ACT_APPEND, 8'hFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, NO_WANT},
			'{isa_pkg::ACT_INSERT, 8'h00, 32'hFFFFFFFF, 32'h00000000, 1'b0, NO_WANT},
			// Insert past the count lands at the end.
			'{isa_pkg::ACT_INSERT, 8'h7F, 32'h00000000, 32'hFFFFFFFF, 1'b0, NO_WANT},
			'{isa_pkg::ACT_INSERT, 8'h02, 32'h55555555, 32'hAAAAAAAA, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h00, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h04, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h05, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'hFF, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h7F, 32'h0, 32'h0, 1'b0, NO_WANT},
			// Removes out of range, in the middle, at the end and at the front.
			'{isa_pkg::ACT_REMOVE, 8'h80, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_REMOVE, 8'h05, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_REMOVE, 8'h02, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_REMOVE, 8'h03, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_REMOVE, 8'h00, 32'h0, 32'h0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h00, 32'h0, 32'h0, 1'b0, NO_WANT},
			// Insert exactly at the count appends.
			'{isa_pkg::ACT_INSERT, 8'h02, 32'h12345678, 32'h9ABCDEF0, 1'b0, NO_WANT},
			'{isa_pkg::ACT_READ,   8'h02, 32'h0, 32'h0, 1'b0, NO_WANT}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].pri,
				dir_tab[i].typed, dir_tab[i].want);

		// Random phases that fill the list to capacity, drain it and mix both.
		phase = 0;
		while (n_sent < ITEMS_TOTAL) begin
			mode = phase % 3;
			calm = (phase == 3);
			phase_len = (mode == 2) ? $urandom_range(40, 100) : $urandom_range(110, 160);
			for (int k = 0; k < phase_len && n_sent < ITEMS_TOTAL; k++) begin
				roll = $urandom_range(99);
				case (mode)
					0: act = (roll < 40) ? isa_pkg::ACT_APPEND :
						(roll < 80) ? isa_pkg::ACT_INSERT :
						(roll < 92) ? isa_pkg::ACT_READ : isa_pkg::ACT_REMOVE;
					1: act = (roll < 60) ? isa_pkg::ACT_REMOVE :
						(roll < 80) ? isa_pkg::ACT_READ :
						(roll < 90) ? isa_pkg::ACT_APPEND : isa_pkg::ACT_INSERT;
					default: act = isa_pkg::action_t'(roll % 4);
				endcase
				roll = $urandom_range(99);
				if (roll < 70) begin
					idx = isa_pkg::IDX_W'($urandom_range(0, shadow_len));
				end else if (roll < 85) begin
					idx = isa_pkg::IDX_W'($urandom_range(0, 255));
				end else begin
					case ($urandom_range(3))
						0: idx = 8'h80;
						1: idx = 8'hFF;
						2: idx = 8'h7F;
						default: idx = isa_pkg::IDX_W'(shadow_len > 0 ? shadow_len - 1 : 0);
					endcase
				end
				send_item(act, idx, $urandom, $urandom, 1'b0, NO_WANT);
			end
			// Hold off until the list has answered every item so far.
			start <= 1'b0;
			while (owed_results.size() != 0) @(posedge clk);
			phase++;
		end

		start <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items, checked %0d results: %0d ok, %0d out of range, %0d full.",
			n_sent, n_checked, n_ok, n_range, n_full);
		$display("Longest list held %0d entries of %0d; %0d errors found.",
			peak_len, isa_pkg::DEPTH, n_bad);
		if (n_bad == 0 && owed_results.size() == 0) begin
			$display("indexed_shift_array_tb passed");
		end else begin
			$display("indexed_shift_array_tb failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("indexed_shift_array_tb failed");
		$finish;
	end

endmodule

>>> indexed_shift_array.f
sv/isa_pkg.sv
sv/isa_cell.sv
sv/indexed_shift_array.sv
dv/indexed_shift_array_tb.sv
